/* rtl/planar_texture_coordinate_map_unit_macros.svh */
// Assertion macros shared by the block's modules.
`ifndef PLANAR_TEXTURE_COORDINATE_MAP_UNIT_MACROS_SVH
`define PLANAR_TEXTURE_COORDINATE_MAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PTCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PTCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PTCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTCM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/ptcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcm_pkg
// Types and codes shared by the planar texture coordinate mapping block.
// ----------------------------------------------------------------------------
package ptcm_pkg;
	localparam logic [1:0] ACT_RESTART = 2'd0;
	localparam logic [1:0] ACT_MEASURE = 2'd1;
	localparam logic [1:0] ACT_MAP     = 2'd2;
	localparam logic [1:0] MODE_PLANAR  = 2'd1;
	localparam logic [1:0] MODE_STRETCH = 2'd2;
	localparam logic [1:0] AXIS_PLAN  = 2'd0;
	localparam logic [1:0] AXIS_FRONT = 2'd1;
	localparam logic [1:0] AXIS_SIDE  = 2'd2;
	localparam logic [2:0] REG_MAP_MODE = 3'd0;
	localparam logic [2:0] REG_AXIS     = 3'd1;
	localparam logic [2:0] REG_SCALE_U  = 3'd2;
	localparam logic [2:0] REG_SCALE_V  = 3'd3;
	localparam logic [2:0] REG_FLIP_V   = 3'd4;
	localparam logic [2:0] REG_MIRROR_U = 3'd5;
	localparam logic [2:0] REG_ROTATE   = 3'd6;

	typedef struct packed {
		logic        stretch;
		logic        rotate;
		logic        mirror;
		logic        flip;
		logic [3:0]  corner;
		logic [15:0] vid;
		logic [23:0] scale_u;
		logic [23:0] scale_v;
		logic [32:0] d_u;
		logic [32:0] r_u;
		logic [32:0] d_v;
		logic [32:0] r_v;
	} job_t;
endpackage

/* rtl/ptcm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcm_front
// Accepts requests, projects vertices, keeps the bounds and issues map jobs.
// ----------------------------------------------------------------------------
module ptcm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic [3:0]           corner_index,
	input  logic [15:0]          vertex_id,
	input  logic [1:0]           map_mode,
	input  logic [1:0]           projection_axis,
	input  logic [23:0]          scale_u,
	input  logic [23:0]          scale_v,
	input  logic                 flip_v,
	input  logic                 mirror_u,
	input  logic                 rotate_uv,
	input  logic                 job_full,
	output logic                 job_push,
	output ptcm_pkg::job_t       job
);
	logic signed [31:0] low_u_q, high_u_q, low_v_q, high_v_q;
	logic signed [31:0] pu, pv, nsrc, nv;
	logic acc, is_map;

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
		neg_sat = (a == 32'sh8000_0000) ? 32'sh7fff_ffff : -a;
	endfunction

	always_comb begin
		pu = (projection_axis == ptcm_pkg::AXIS_SIDE) ? pos_z : pos_x;
		nsrc = (projection_axis == ptcm_pkg::AXIS_FRONT) ? pos_z : pos_y;
		nv = neg_sat(nsrc);
		pv = nv;
	end

	assign is_map = (action == ptcm_pkg::ACT_MAP) &&
		(map_mode == ptcm_pkg::MODE_PLANAR || map_mode == ptcm_pkg::MODE_STRETCH);
	assign in_ready = !job_full;
	assign acc = in_valid && in_ready;
	assign job_push = acc && is_map;

	always_comb begin
		job.stretch = (map_mode == ptcm_pkg::MODE_STRETCH);
		job.rotate = rotate_uv;
		job.mirror = mirror_u;
		job.flip = flip_v;
		job.corner = corner_index;
		job.vid = vertex_id;
		job.scale_u = scale_u;
		job.scale_v = scale_v;
		job.d_u = {pu[31], pu} - {low_u_q[31], low_u_q};
		job.r_u = {high_u_q[31], high_u_q} - {low_u_q[31], low_u_q};
		job.d_v = {pv[31], pv} - {low_v_q[31], low_v_q};
		job.r_v = {high_v_q[31], high_v_q} - {low_v_q[31], low_v_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_u_q <= 32'sh7fff_ffff;
			high_u_q <= 32'sh8000_0000;
			low_v_q <= 32'sh7fff_ffff;
			high_v_q <= 32'sh8000_0000;
		end else if (acc) begin
			if (action == ptcm_pkg::ACT_RESTART) begin
				low_u_q <= 32'sh7fff_ffff;
				high_u_q <= 32'sh8000_0000;
				low_v_q <= 32'sh7fff_ffff;
				high_v_q <= 32'sh8000_0000;
			end else if (action == ptcm_pkg::ACT_MEASURE) begin
				if (pu < low_u_q) low_u_q <= pu;
				if (pu > high_u_q) high_u_q <= pu;
				if (pv < low_v_q) low_v_q <= pv;
				if (pv > high_v_q) high_v_q <= pv;
			end
		end
	end
endmodule

/* rtl/ptcm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ptcm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptcm_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output ptcm_pkg::job_t dout
);
	`include "planar_texture_coordinate_map_unit_macros.svh"
	ptcm_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q[1];
	assign not_empty = (cnt_q != 2'd0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`PTCM_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full)
	`PTCM_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, not_empty)
	`PTCM_ASSERT_IMP(a_count_ptr, clk, arst_n, cnt_q == 2'd1, wp_q != rp_q)
endmodule

/* rtl/ptcm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcm_back
// Works out texture coordinates with one shared restoring divider.
// ----------------------------------------------------------------------------
module ptcm_back #(
	parameter int SCALE_FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  ptcm_pkg::job_t job,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    result_vertex,
	output logic [23:0]    tex_u,
	output logic [23:0]    tex_v
);
	`include "planar_texture_coordinate_map_unit_macros.svh"
	localparam logic [23:0] ONE = 24'(1 << SCALE_FRAC_BITS);
	localparam logic [23:0] THR = 24'(((1 << SCALE_FRAC_BITS) + 999) / 1000);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_OUT = 4'b1000
	} state_t;

	state_t state_q;
	ptcm_pkg::job_t job_q;
	logic sel_q;
	logic [5:0] cnt_q;
	logic [56:0] num_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic neg_q;
	logic signed [58:0] qu_q, qv_q;
	logic [15:0] vid_q;
	logic [23:0] tu_q, tv_q;
	logic ov_q;

	logic [32:0] dsel, rsel, dmag;
	logic [23:0] ssel;
	logic [56:0] prod;
	logic [33:0] trial;
	logic signed [58:0] iu, iv;
	logic [23:0] su, sv, pu_t, pv_t;
	logic a, b;

	function automatic logic [23:0] clamp24(input logic signed [58:0] x);
		if (x < 0) clamp24 = 24'd0;
		else if (x > 59'sd16777215) clamp24 = 24'hffffff;
		else clamp24 = x[23:0];
	endfunction

	always_comb begin
		dsel = sel_q ? job_q.d_v : job_q.d_u;
		rsel = sel_q ? job_q.r_v : job_q.r_u;
		ssel = sel_q ? job_q.scale_v : job_q.scale_u;
		dmag = dsel[32] ? -dsel : dsel;
		prod = {33'd0, ssel} * {24'd0, dmag};
		trial = {rem_q[32:0], num_q[56]} - {1'b0, den_q};
		iu = $signed({35'd0, job_q.scale_u}) - qu_q;
		iv = $signed({35'd0, job_q.scale_v}) - qv_q;
		su = (job_q.scale_u < THR) ? ONE : job_q.scale_u;
		sv = (job_q.scale_v < THR) ? ONE : job_q.scale_v;
		a = (job_q.corner > 4'd0) && (job_q.corner < 4'd3);
		b = (job_q.corner > 4'd1);
		if (!job_q.rotate) begin
			pu_t = ((job_q.mirror ? !a : a)) ? su : 24'd0;
			pv_t = ((job_q.flip ? !b : b)) ? sv : 24'd0;
		end else begin
			pv_t = ((job_q.mirror ? a : !a)) ? sv : 24'd0;
			pu_t = ((job_q.flip ? !b : b)) ? su : 24'd0;
		end
	end

	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign out_valid = ov_q;
	assign result_vertex = vid_q;
	assign tex_u = tu_q;
	assign tex_v = tv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			sel_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			if (state_q == S_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						sel_q <= 1'b0;
						state_q <= job.stretch ? S_OUT : S_MUL;
					end
				end
				S_MUL: begin
					num_q <= prod;
					den_q <= rsel;
					neg_q <= dsel[32];
					rem_q <= 34'd0;
					cnt_q <= 6'd0;
					if (rsel[32] || rsel == 33'd0) begin
						if (sel_q) qv_q <= 59'sd0; else qu_q <= 59'sd0;
						if (sel_q) state_q <= S_OUT; else sel_q <= 1'b1;
					end else state_q <= S_DIV;
				end
				S_DIV: begin
					if (!trial[33]) begin
						rem_q <= trial;
						num_q <= {num_q[55:0], 1'b1};
					end else begin
						rem_q <= {rem_q[32:0], num_q[56]};
						num_q <= {num_q[55:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd56) begin
						if (sel_q) begin
							qv_q <= $signed(neg_q ? -{2'b00, num_q[55:0], !trial[33]}
								: {2'b00, num_q[55:0], !trial[33]});
							state_q <= S_OUT;
						end else begin
							qu_q <= $signed(neg_q ? -{2'b00, num_q[55:0], !trial[33]}
								: {2'b00, num_q[55:0], !trial[33]});
							sel_q <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_OUT: begin
					if (!ov_q || out_ready) begin
						vid_q <= job_q.vid;
						if (job_q.stretch) begin
							tu_q <= pu_t;
							tv_q <= pv_t;
						end else if (!job_q.rotate) begin
							tu_q <= clamp24(job_q.mirror ? iu : qu_q);
							tv_q <= clamp24(job_q.flip ? iv : qv_q);
						end else begin
							tv_q <= clamp24(job_q.mirror ? qu_q : iu);
							tu_q <= clamp24(job_q.flip ? iv : qv_q);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTCM_ASSERT_NXT(a_out_hold, clk, arst_n, ov_q && !out_ready, ov_q && $stable(tu_q))
	`PTCM_ASSERT_IMP(a_pop_idle, clk, arst_n, job_pop, state_q == S_IDLE)
	`PTCM_ASSERT_IMP(a_div_den, clk, arst_n, state_q == S_DIV, den_q != 33'd0)
endmodule

/* rtl/planar_texture_coordinate_map_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_texture_coordinate_map_unit
// Planar and stretch texture coordinate mapping for streamed vertices.
// ----------------------------------------------------------------------------
// Restart and measure requests are handled in the front part alone. A map
// request in planar mode is worked out in the back part, where the two
// coordinates share one restoring divider that retires one quotient bit of a
// 57-bit numerator per cycle. Stretch map requests skip the divider. A two-entry
// queue lets the front keep measuring while the back divides.
module planar_texture_coordinate_map_unit #(
	parameter int SCALE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [3:0]         corner_index,
	input  logic [15:0]        vertex_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        result_vertex,
	output logic [23:0]        tex_u,
	output logic [23:0]        tex_v
);
	logic [1:0] map_mode_q, axis_q;
	logic [23:0] scale_u_q, scale_v_q;
	logic flip_q, mirror_q, rotate_q;
	logic push, full, pop, nempty;
	ptcm_pkg::job_t jin, jout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q <= ptcm_pkg::MODE_PLANAR;
			axis_q <= ptcm_pkg::AXIS_PLAN;
			scale_u_q <= 24'(1 << SCALE_FRAC_BITS);
			scale_v_q <= 24'(1 << SCALE_FRAC_BITS);
			flip_q <= 1'b0;
			mirror_q <= 1'b0;
			rotate_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptcm_pkg::REG_MAP_MODE: map_mode_q <= cfg_data[1:0];
				ptcm_pkg::REG_AXIS:     axis_q <= cfg_data[1:0];
				ptcm_pkg::REG_SCALE_U:  scale_u_q <= cfg_data;
				ptcm_pkg::REG_SCALE_V:  scale_v_q <= cfg_data;
				ptcm_pkg::REG_FLIP_V:   flip_q <= cfg_data[0];
				ptcm_pkg::REG_MIRROR_U: mirror_q <= cfg_data[0];
				ptcm_pkg::REG_ROTATE:   rotate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ptcm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_index(corner_index), .vertex_id(vertex_id),
		.map_mode(map_mode_q), .projection_axis(axis_q),
		.scale_u(scale_u_q), .scale_v(scale_v_q), .flip_v(flip_q),
		.mirror_u(mirror_q), .rotate_uv(rotate_q),
		.job_full(full), .job_push(push), .job(jin)
	);

	ptcm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(jin), .full(full),
		.pop(pop), .not_empty(nempty), .dout(jout)
	);

	ptcm_back #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(nempty), .job(jout), .job_pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .result_vertex(result_vertex),
		.tex_u(tex_u), .tex_v(tex_v)
	);
endmodule

/* test/tb_planar_texture_coordinate_map_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_texture_coordinate_map_unit
// Streams restart, measure and map requests through the texture coordinate
// mapper under a series of register settings, with random gaps on both sides.
// Each accepted request is run through a local model of the bounds and the
// planar and stretch arithmetic, and every returned coordinate is compared
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_planar_texture_coordinate_map_unit;
	localparam logic [1:0] ACT_NOP     = 2'd3;
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam int         STUCK_LIMIT = 20000;
	localparam int         DRAIN_WAIT  = 200;
	localparam int         NUM_PHASES  = 12;
	localparam logic signed [31:0] POS_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] NEG_MIN = 32'sh80000000;

	typedef struct {
		logic [1:0]         act;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [3:0]         corner;
		logic [15:0]        vid;
	} vert_req_t;

	typedef struct {
		logic [15:0] vid;
		logic [23:0] u;
		logic [23:0] v;
	} tex_coord_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [3:0]         corner_index;
	logic [15:0]        vertex_id;
	logic               out_valid;
	logic               out_ready;
	logic [15:0]        result_vertex;
	logic [23:0]        tex_u;
	logic [23:0]        tex_v;

	vert_req_t  pending_reqs[$];
	tex_coord_t coords_due[$];
	int         errors;
	int         send_gap;
	int         recv_gap;
	int         stuck_cycles;
	bit         quiet;
	logic [15:0] next_vid;

	logic [1:0]  m_mode;
	logic [1:0]  m_axis;
	logic [23:0] m_scale_u;
	logic [23:0] m_scale_v;
	logic        m_flip;
	logic        m_mirror;
	logic        m_rotate;
	logic signed [31:0] lo_u, hi_u, lo_v, hi_v;

	planar_texture_coordinate_map_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_index(corner_index), .vertex_id(vertex_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_vertex(result_vertex), .tex_u(tex_u), .tex_v(tex_v)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic signed [31:0] negate_sat(input logic signed [31:0] a);
		if (a == NEG_MIN)
			return POS_MAX;
		return -a;
	endfunction

	function automatic logic [23:0] clamp_coord(input longint a);
		if (a < 0)
			return 24'd0;
		if (a > 64'sd16777215)
			return 24'hffffff;
		return a[23:0];
	endfunction

	function automatic longint span_fraction(input logic [23:0] scale,
			input logic signed [31:0] p, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		longint span;
		longint offs;
		span = longint'(hi) - longint'(lo);
		offs = longint'(p) - longint'(lo);
		if (span <= 0)
			return 0;
		return (longint'({40'd0, scale}) * offs) / span;
	endfunction

	function automatic bit predict_coord(input vert_req_t r, output tex_coord_t e);
		logic signed [31:0] pu, pv;
		longint qu, qv, iu, iv;
		logic [23:0] su, sv;
		bit a, b;
		e.vid = r.vid;
		e.u = '0;
		e.v = '0;
		if (r.act == ptcm_pkg::ACT_RESTART) begin
			lo_u = POS_MAX;
			hi_u = NEG_MIN;
			lo_v = POS_MAX;
			hi_v = NEG_MIN;
			return 0;
		end
		if (r.act == ACT_NOP)
			return 0;
		case (m_axis)
			ptcm_pkg::AXIS_FRONT: begin
				pu = r.x;
				pv = negate_sat(r.z);
			end
			ptcm_pkg::AXIS_SIDE: begin
				pu = r.z;
				pv = negate_sat(r.y);
			end
			default: begin
				pu = r.x;
				pv = negate_sat(r.y);
			end
		endcase
		if (r.act == ptcm_pkg::ACT_MEASURE) begin
			if (pu < lo_u) lo_u = pu;
			if (pu > hi_u) hi_u = pu;
			if (pv < lo_v) lo_v = pv;
			if (pv > hi_v) hi_v = pv;
			return 0;
		end
		if (m_mode == ptcm_pkg::MODE_PLANAR) begin
			qu = span_fraction(m_scale_u, pu, lo_u, hi_u);
			qv = span_fraction(m_scale_v, pv, lo_v, hi_v);
			iu = longint'({40'd0, m_scale_u}) - qu;
			iv = longint'({40'd0, m_scale_v}) - qv;
			if (!m_rotate) begin
				e.u = clamp_coord(m_mirror ? iu : qu);
				e.v = clamp_coord(m_flip ? iv : qv);
			end else begin
				e.v = clamp_coord(m_mirror ? qu : iu);
				e.u = clamp_coord(m_flip ? iv : qv);
			end
			return 1;
		end
		if (m_mode == ptcm_pkg::MODE_STRETCH) begin
			su = (m_scale_u < 24'd66) ? 24'h010000 : m_scale_u;
			sv = (m_scale_v < 24'd66) ? 24'h010000 : m_scale_v;
			a = (r.corner > 0) && (r.corner < 3);
			b = r.corner > 1;
			if (!m_rotate) begin
				e.u = (m_mirror ? !a : a) ? su : 24'd0;
				e.v = (m_flip ? !b : b) ? sv : 24'd0;
			end else begin
				e.v = (m_mirror ? a : !a) ? sv : 24'd0;
				e.u = (m_flip ? !b : b) ? su : 24'd0;
			end
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		tex_coord_t e;
		vert_req_t  r;
		bit         busy;
		if (arst_n) begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				stuck_cycles = 0;
				busy = 0;
				r.act = action;
				r.x = pos_x;
				r.y = pos_y;
				r.z = pos_z;
				r.corner = corner_index;
				r.vid = vertex_id;
				if (predict_coord(r, e))
					coords_due.insert(coords_due.size(), e);
			end
			if (busy) begin
				in_valid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				action <= r.act;
				pos_x <= r.x;
				pos_y <= r.y;
				pos_z <= r.z;
				corner_index <= r.corner;
				vertex_id <= r.vid;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					send_gap = $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tex_coord_t e;
		if (arst_n) begin
			stuck_cycles++;
			if (out_valid && out_ready) begin
				stuck_cycles = 0;
				if (coords_due.size() == 0) begin
					report_mismatch("unexpected result_vertex", {8'd0, result_vertex},
						24'd0);
				end else begin
					e = coords_due.pop_front();
					if (result_vertex !== e.vid)
						report_mismatch("result_vertex", {8'd0, result_vertex}, {8'd0, e.vid});
					if (tex_u !== e.u)
						report_mismatch("tex_u", tex_u, e.u);
					if (tex_v !== e.v)
						report_mismatch("tex_v", tex_v, e.v);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic add_req(input logic [1:0] act, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z,
			input logic [3:0] corner);
		vert_req_t r;
		r.act = act;
		r.x = x;
		r.y = y;
		r.z = z;
		r.corner = corner;
		r.vid = next_vid;
		next_vid = next_vid + 16'd1 + 16'($urandom_range(0, 600));
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] c;
		if ($urandom_range(0, 7) == 0)
			c = $urandom;
		else
			c = $signed(32'($urandom_range(0, 32'h200000))) - 32'sh100000;
		if (c == NEG_MIN)
			c = NEG_MIN + 1;
		return c;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			ptcm_pkg::REG_MAP_MODE: m_mode = val[1:0];
			ptcm_pkg::REG_AXIS:     m_axis = val[1:0];
			ptcm_pkg::REG_SCALE_U:  m_scale_u = val;
			ptcm_pkg::REG_SCALE_V:  m_scale_v = val;
			ptcm_pkg::REG_FLIP_V:   m_flip = val[0];
			ptcm_pkg::REG_MIRROR_U: m_mirror = val[0];
			ptcm_pkg::REG_ROTATE:   m_rotate = val[0];
			default: ;
		endcase
	endtask

	function automatic logic [23:0] pick_scale(input int k);
		case (k % 6)
			0: return 24'd0;
			1: return 24'd65;
			2: return 24'd66;
			3: return 24'hffffff;
			4: return 24'h010000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_reqs.size() != 0 || in_valid || coords_due.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	initial begin
		logic [1:0] mode;
		logic [3:0] p;
		int k;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ptcm_pkg::ACT_RESTART;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		corner_index = '0;
		vertex_id = '0;
		out_ready = 1'b0;
		errors = 0;
		send_gap = 0;
		recv_gap = 0;
		stuck_cycles = 0;
		quiet = 0;
		next_vid = 16'hfff0;
		m_mode = ptcm_pkg::MODE_PLANAR;
		m_axis = ptcm_pkg::AXIS_PLAN;
		m_scale_u = 24'h010000;
		m_scale_v = 24'h010000;
		m_flip = 0;
		m_mirror = 0;
		m_rotate = 0;
		lo_u = POS_MAX;
		hi_u = NEG_MIN;
		lo_v = POS_MAX;
		hi_v = NEG_MIN;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_req(ptcm_pkg::ACT_MAP, 32'sd5, 32'sd5, 32'sd5, 4'd0);
		add_req(ptcm_pkg::ACT_MEASURE, 32'sd0, 32'sd0, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MAP, 32'sd0, 32'sd0, 32'sd0, 4'd15);
		add_req(ptcm_pkg::ACT_MEASURE, POS_MAX, POS_MAX, POS_MAX, 4'd0);
		add_req(ptcm_pkg::ACT_MEASURE, -POS_MAX, -POS_MAX, -POS_MAX, 4'd0);
		add_req(ptcm_pkg::ACT_MAP, POS_MAX, POS_MAX, POS_MAX, 4'd1);
		add_req(ptcm_pkg::ACT_MAP, -POS_MAX, -POS_MAX, -POS_MAX, 4'd2);
		add_req(ptcm_pkg::ACT_MAP, 32'sd0, 32'sd0, 32'sd0, 4'd3);
		add_req(ACT_NOP, 32'sd7, 32'sd7, 32'sd7, 4'd9);
		add_req(ptcm_pkg::ACT_RESTART, 32'sd0, 32'sd0, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MEASURE, 32'sh10000, -32'sh10000, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MEASURE, 32'sh30000, 32'sh20000, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MAP, 32'sh20000, 32'sd0, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MAP, 32'sh7fff0000, -32'sh7fff0000, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MAP, -32'sh7fff0000, 32'sh7fff0000, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_RESTART, 32'sd0, 32'sd0, 32'sd0, 4'd0);
		add_req(ptcm_pkg::ACT_MAP, 32'sd1, 32'sd1, 32'sd1, 4'd0);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			p = 4'(ph);
			if (ph == NUM_PHASES - 1)
				quiet = 1;
			if (ph < 8)
				mode = p[0] ? ptcm_pkg::MODE_STRETCH : ptcm_pkg::MODE_PLANAR;
			else if (ph == 8)
				mode = MODE_NONE;
			else if (ph == 9)
				mode = MODE_SPARE;
			else if (ph == 10)
				mode = ptcm_pkg::MODE_STRETCH;
			else
				mode = ptcm_pkg::MODE_PLANAR;
			write_reg(ptcm_pkg::REG_MAP_MODE, {22'd0, mode});
			write_reg(ptcm_pkg::REG_AXIS, {22'd0, p[1:0]});
			write_reg(ptcm_pkg::REG_SCALE_U, pick_scale(ph));
			write_reg(ptcm_pkg::REG_SCALE_V, pick_scale(ph + 3));
			write_reg(ptcm_pkg::REG_FLIP_V, {23'd0, p[1]});
			write_reg(ptcm_pkg::REG_MIRROR_U, {23'd0, p[2] ^ p[0]});
			write_reg(ptcm_pkg::REG_ROTATE, {23'd0, p[0] ^ p[1] ^ p[3]});
			@(posedge clk);
			cfg_we <= 1'b0;
			add_req(ptcm_pkg::ACT_RESTART, 32'sd0, 32'sd0, 32'sd0, 4'd0);
			for (int i = 0; i < 4; i++)
				add_req(ptcm_pkg::ACT_MEASURE, rand_coord(), rand_coord(), rand_coord(), 4'd0);
			for (int i = 0; i < 85; i++) begin
				k = $urandom_range(0, 19);
				if (k == 0)
					add_req(ACT_NOP, rand_coord(), rand_coord(), rand_coord(), 4'($urandom));
				else if (k == 1)
					add_req(ptcm_pkg::ACT_RESTART, rand_coord(), rand_coord(), rand_coord(),
						4'($urandom));
				else if (k < 7)
					add_req(ptcm_pkg::ACT_MEASURE, rand_coord(), rand_coord(), rand_coord(),
						4'($urandom));
				else
					add_req(ptcm_pkg::ACT_MAP, rand_coord(), rand_coord(), rand_coord(),
						4'($urandom));
			end
		end

		do begin
			@(posedge clk);
			#1;
		end while (pending_reqs.size() != 0 || in_valid || coords_due.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && coords_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
